// File: src/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types, codes and rectangle helpers of the rectangle region engine.
// ----------------------------------------------------------------------------
package rre_pkg;

	localparam int MAX_RECTS  = 16;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_RECTS);
	localparam int CNT_W      = $clog2(MAX_RECTS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECTS);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [2:0] {
		REQ_ADD   = 3'd0,
		REQ_SUB   = 3'd1,
		REQ_CLIP  = 3'd2,
		REQ_OFS   = 3'd3,
		REQ_CLEAR = 3'd4,
		REQ_TIDY  = 3'd5,
		REQ_QUERY = 3'd6,
		REQ_READ  = 3'd7
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_PIECE  = 2'd1,
		KIND_ENTRY  = 2'd2,
		KIND_RANGE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]       req_type;
		coord_t           rect_left;
		coord_t           rect_top;
		coord_t           rect_right;
		coord_t           rect_bottom;
		coord_t           point_x;
		coord_t           point_y;
		logic [IDX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		coord_t           out_left;
		coord_t           out_top;
		coord_t           out_right;
		coord_t           out_bottom;
		logic [CNT_W-1:0] rect_count;
		logic             error_flag;
		logic             point_inside;
		logic             rect_overlaps;
		logic             region_enclosed;
		logic             region_empty;
		logic             last;
	} rsp_t;

	typedef struct packed {
		coord_t l;
		coord_t t;
		coord_t r;
		coord_t b;
	} box_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_BB, S_ADD_DEC, S_MG_FIND, S_SCAN, S_DEL, S_FRAG,
		S_SPL_DONE, S_EMIT_PIECE, S_APPEND_OP, S_CLIP, S_OFS, S_TIDY_START,
		S_PASS_INIT, S_TIDY_A, S_TIDY_P, S_TIDY_MV, S_PASS_END, S_STATUS
	} state_t;

	// store write data source
	typedef enum logic [2:0] {
		W_OP, W_RD, W_FRAG, W_CLIP, W_OFS, W_TIDY
	} wsrc_t;

	// rectangle shown on an emitted result
	typedef enum logic [1:0] {
		SHOW_ZERO, SHOW_PIECE, SHOW_BB, SHOW_RD
	} show_t;

	typedef enum logic [1:0] {
		CNT_HOLD, CNT_ZERO, CNT_INC, CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic             capture;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		wsrc_t            wr_src;
		logic [1:0]       frag_sel;
		logic             cols;
		logic             load_e;
		logic             load_a;
		logic             bb_init;
		logic             bb_acc;
		logic             q_init;
		logic             q_acc;
		cnt_op_t          cnt_op;
		logic             err_set;
		logic             err_clr;
		logic             emit;
		kind_t            kind;
		show_t            show;
		logic             use_q;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             err;
		logic             op_empty;
		logic             rd_ovl;
		logic             rd_encl;
		logic             clip_empty;
		logic             tidy_hit;
		logic [3:0]       frag_need;
		logic             bb_in_empty;
		logic             bb_in_same;
		logic             in_op_same;
		logic             out_free;
	} dp_stat_t;

	function automatic logic is_empty(box_t a);
		return (a.l >= a.r) || (a.t >= a.b);
	endfunction

	function automatic logic overlap(box_t a, box_t b);
		return (a.r > b.l) && (a.b > b.t) && (a.l < b.r) && (a.t < b.b);
	endfunction

	function automatic box_t isect(box_t a, box_t b);
		box_t o;
		o.l = (a.l > b.l) ? a.l : b.l;
		o.t = (a.t > b.t) ? a.t : b.t;
		o.r = (a.r < b.r) ? a.r : b.r;
		o.b = (a.b < b.b) ? a.b : b.b;
		return o;
	endfunction

	// saturating add in the signed coordinate range
	function automatic coord_t sat_add(coord_t a, coord_t d);
		logic signed [COORD_BITS:0] s;
		coord_t res;
		s = {a[COORD_BITS-1], a} + {d[COORD_BITS-1], d};
		if (s[COORD_BITS] != s[COORD_BITS-1])
			res = s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
			                    : {1'b0, {(COORD_BITS-1){1'b1}}};
		else
			res = s[COORD_BITS-1:0];
		return res;
	endfunction

endpackage

// File: src/rre_dp.sv
// ----------------------------------------------------------------------------
// rre_dp
// Datapath: rectangle store, count, error flag, operand, work registers,
// compare logic and the result output register.
// ----------------------------------------------------------------------------
module rre_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rre_pkg::req_t     req,
	input  rre_pkg::dp_cmd_t  cmd,
	output rre_pkg::dp_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rre_pkg::rsp_t     rsp
);

	rre_pkg::box_t                 store_q [rre_pkg::MAX_RECTS];
	logic [rre_pkg::CNT_W-1:0]     cnt_q;
	logic                          err_q;
	rre_pkg::box_t                 op_q;
	rre_pkg::coord_t               px_q;
	rre_pkg::coord_t               py_q;
	rre_pkg::box_t                 e_q;
	rre_pkg::box_t                 a_q;
	rre_pkg::box_t                 bb_q;
	logic                          qin_q;
	logic                          qovl_q;
	logic                          qencl_q;
	rre_pkg::rsp_t                 rsp_q;
	logic                          rsp_valid_q;

	rre_pkg::box_t rd;
	rre_pkg::box_t clip_b;
	rre_pkg::box_t ofs_b;
	rre_pkg::box_t in_e;
	rre_pkg::box_t frag_b;
	rre_pkg::box_t tidy_b;
	rre_pkg::box_t bb_in;
	rre_pkg::box_t wr_data;
	rre_pkg::box_t show_b;
	rre_pkg::box_t zero_b;
	logic          out_free;
	logic          tidy_hit;

	assign rd     = store_q[cmd.rd_addr];
	assign zero_b = '0;

	// clipped and shifted versions of the read entry
	always_comb begin
		clip_b.l = (rd.l < op_q.l) ? op_q.l : rd.l;
		clip_b.t = (rd.t < op_q.t) ? op_q.t : rd.t;
		clip_b.r = (rd.r > op_q.r) ? op_q.r : rd.r;
		clip_b.b = (rd.b > op_q.b) ? op_q.b : rd.b;
		ofs_b.l  = rre_pkg::sat_add(rd.l, px_q);
		ofs_b.r  = rre_pkg::sat_add(rd.r, px_q);
		ofs_b.t  = rre_pkg::sat_add(rd.t, py_q);
		ofs_b.b  = rre_pkg::sat_add(rd.b, py_q);
	end

	// fragments of the split entry around its overlap
	assign in_e = rre_pkg::isect(op_q, e_q);
	always_comb begin
		case (cmd.frag_sel)
			2'd0:    frag_b = '{l: e_q.l,  t: in_e.b, r: e_q.r,  b: e_q.b};
			2'd1:    frag_b = '{l: e_q.l,  t: e_q.t,  r: e_q.r,  b: in_e.t};
			2'd2:    frag_b = '{l: in_e.r, t: in_e.t, r: e_q.r,  b: in_e.b};
			default: frag_b = '{l: e_q.l,  t: in_e.t, r: in_e.l, b: in_e.b};
		endcase
	end

	// tidy: neighbor test and merged entry
	always_comb begin
		tidy_b   = rd;
		tidy_hit = 1'b0;
		if (!cmd.cols) begin
			if (a_q.t == rd.t && a_q.b == rd.b) begin
				if (a_q.r == rd.l) begin
					tidy_b.l = a_q.l;
					tidy_hit = 1'b1;
				end else if (a_q.l == rd.r) begin
					tidy_b.r = a_q.r;
					tidy_hit = 1'b1;
				end
			end
		end else begin
			if (a_q.l == rd.l && a_q.r == rd.r) begin
				if (a_q.b == rd.t) begin
					tidy_b.t = a_q.t;
					tidy_hit = 1'b1;
				end else if (a_q.t == rd.b) begin
					tidy_b.b = a_q.b;
					tidy_hit = 1'b1;
				end
			end
		end
	end

	// write data select
	always_comb begin
		unique case (cmd.wr_src)
			rre_pkg::W_OP:   wr_data = op_q;
			rre_pkg::W_RD:   wr_data = rd;
			rre_pkg::W_FRAG: wr_data = frag_b;
			rre_pkg::W_CLIP: wr_data = clip_b;
			rre_pkg::W_OFS:  wr_data = ofs_b;
			rre_pkg::W_TIDY: wr_data = tidy_b;
			default:         wr_data = rd;
		endcase
	end

	// status toward the controller
	assign bb_in = rre_pkg::isect(op_q, bb_q);
	always_comb begin
		stat.cnt          = cnt_q;
		stat.err          = err_q;
		stat.op_empty     = rre_pkg::is_empty(op_q);
		stat.rd_ovl       = rre_pkg::overlap(rd, op_q);
		stat.rd_encl      = (rd.r >= op_q.r) && (rd.b >= op_q.b) &&
		                    (rd.l <= op_q.l) && (rd.t <= op_q.t);
		stat.clip_empty   = rre_pkg::is_empty(clip_b);
		stat.tidy_hit     = tidy_hit;
		stat.frag_need[0] = (in_e.b != e_q.b);
		stat.frag_need[1] = (in_e.t != e_q.t);
		stat.frag_need[2] = (in_e.r != e_q.r);
		stat.frag_need[3] = (in_e.l != e_q.l);
		stat.bb_in_empty  = rre_pkg::is_empty(bb_in);
		stat.bb_in_same   = (bb_in == bb_q);
		stat.in_op_same   = (bb_in == op_q);
		stat.out_free     = out_free;
	end

	// store write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			store_q[cmd.wr_addr] <= wr_data;
	end

	// operand and work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= '{l: req.rect_left, t: req.rect_top,
			          r: req.rect_right, b: req.rect_bottom};
			px_q <= req.point_x;
			py_q <= req.point_y;
		end
		if (cmd.load_e)
			e_q <= rd;
		if (cmd.load_a)
			a_q <= rd;
		if (cmd.bb_init) begin
			bb_q <= rd;
		end else if (cmd.bb_acc) begin
			if (rd.l < bb_q.l) bb_q.l <= rd.l;
			if (rd.t < bb_q.t) bb_q.t <= rd.t;
			if (rd.r > bb_q.r) bb_q.r <= rd.r;
			if (rd.b > bb_q.b) bb_q.b <= rd.b;
		end
	end

	// query flags
	always_ff @(posedge clk) begin
		if (cmd.q_init) begin
			qin_q   <= 1'b0;
			qovl_q  <= 1'b0;
			qencl_q <= 1'b1;
		end else if (cmd.q_acc) begin
			if (px_q >= rd.l && py_q >= rd.t && px_q < rd.r && py_q < rd.b)
				qin_q <= 1'b1;
			if (!rre_pkg::is_empty(op_q) && !rre_pkg::is_empty(rd) &&
			    rre_pkg::overlap(rd, op_q))
				qovl_q <= 1'b1;
			if (rd.l < op_q.l || rd.r > op_q.r || rd.t < op_q.t || rd.b > op_q.b)
				qencl_q <= 1'b0;
		end
	end

	// count and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				rre_pkg::CNT_HOLD: cnt_q <= cnt_q;
				rre_pkg::CNT_ZERO: cnt_q <= '0;
				rre_pkg::CNT_INC:  cnt_q <= cnt_q + 1'b1;
				rre_pkg::CNT_DEC:  cnt_q <= cnt_q - 1'b1;
				default:           cnt_q <= cnt_q;
			endcase
			if (cmd.err_set)
				err_q <= 1'b1;
			else if (cmd.err_clr)
				err_q <= 1'b0;
		end
	end

	// result output register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		unique case (cmd.show)
			rre_pkg::SHOW_ZERO:  show_b = zero_b;
			rre_pkg::SHOW_PIECE: show_b = in_e;
			rre_pkg::SHOW_BB:    show_b = (cnt_q == '0) ? zero_b : bb_q;
			rre_pkg::SHOW_RD:    show_b = rd;
			default:             show_b = zero_b;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			rsp_q.result_kind     <= cmd.kind;
			rsp_q.out_left        <= show_b.l;
			rsp_q.out_top         <= show_b.t;
			rsp_q.out_right       <= show_b.r;
			rsp_q.out_bottom      <= show_b.b;
			rsp_q.rect_count      <= cnt_q;
			rsp_q.error_flag      <= err_q;
			rsp_q.point_inside    <= cmd.use_q & qin_q;
			rsp_q.rect_overlaps   <= cmd.use_q & qovl_q;
			rsp_q.region_enclosed <= cmd.use_q & qencl_q;
			rsp_q.region_empty    <= (cnt_q == '0) && !err_q;
			rsp_q.last            <= cmd.last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/rre_ctrl.sv
// ----------------------------------------------------------------------------
// rre_ctrl
// Controller: request sequencing, list scan indexes and datapath commands.
// ----------------------------------------------------------------------------
module rre_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [2:0]                  req_type,
	input  logic [rre_pkg::IDX_W-1:0]   entry_index,
	input  rre_pkg::dp_stat_t           stat,
	output rre_pkg::dp_cmd_t            cmd
);

	rre_pkg::state_t            state_q, state_d;
	rre_pkg::req_type_t         typ_q, typ_d;
	logic [rre_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [rre_pkg::CNT_W-1:0]  i_q, i_d;
	logic [rre_pkg::CNT_W-1:0]  j_q, j_d;
	logic [rre_pkg::CNT_W-1:0]  lim_q, lim_d;
	logic [rre_pkg::CNT_W-1:0]  last_q, last_d;
	logic [1:0]                 frag_q, frag_d;
	logic [1:0]                 more_q, more_d;
	logic                       merged_q, merged_d;
	logic                       cols_q, cols_d;
	logic                       sub_q, sub_d;
	logic                       clipdel_q, clipdel_d;
	logic [rre_pkg::CNT_W-1:0]  j_inc;
	logic [1:0]                 more_m;

	assign j_inc  = j_q + 1'b1;
	assign more_m = merged_q ? 2'd1 : more_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rre_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencing registers
	always_ff @(posedge clk) begin
		typ_q     <= typ_d;
		idx_q     <= idx_d;
		i_q       <= i_d;
		j_q       <= j_d;
		lim_q     <= lim_d;
		last_q    <= last_d;
		frag_q    <= frag_d;
		more_q    <= more_d;
		merged_q  <= merged_d;
		cols_q    <= cols_d;
		sub_q     <= sub_d;
		clipdel_q <= clipdel_d;
	end

	assign req_stall = (state_q != rre_pkg::S_IDLE);

	// next state and commands
	always_comb begin
		state_d   = state_q;
		typ_d     = typ_q;
		idx_d     = idx_q;
		i_d       = i_q;
		j_d       = j_q;
		lim_d     = lim_q;
		last_d    = last_q;
		frag_d    = frag_q;
		more_d    = more_q;
		merged_d  = merged_q;
		cols_d    = cols_q;
		sub_d     = sub_q;
		clipdel_d = clipdel_q;
		cmd       = '0;
		cmd.cols  = cols_q;

		unique case (state_q)
			rre_pkg::S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					typ_d       = rre_pkg::req_type_t'(req_type);
					idx_d       = entry_index;
					state_d     = rre_pkg::S_DISPATCH;
				end
			end

			rre_pkg::S_DISPATCH: begin
				i_d = '0;
				unique case (typ_q)
					rre_pkg::REQ_ADD: begin
						sub_d = 1'b0;
						if (stat.op_empty || stat.err)
							state_d = rre_pkg::S_STATUS;
						else if (stat.cnt == '0)
							state_d = rre_pkg::S_APPEND_OP;
						else
							state_d = rre_pkg::S_BB;
					end
					rre_pkg::REQ_SUB: begin
						sub_d     = 1'b1;
						clipdel_d = 1'b0;
						lim_d     = stat.cnt;
						state_d   = stat.op_empty ? rre_pkg::S_STATUS : rre_pkg::S_SCAN;
					end
					rre_pkg::REQ_CLIP:  state_d = rre_pkg::S_CLIP;
					rre_pkg::REQ_OFS:   state_d = rre_pkg::S_OFS;
					rre_pkg::REQ_CLEAR: begin
						cmd.cnt_op  = rre_pkg::CNT_ZERO;
						cmd.err_clr = 1'b1;
						state_d     = rre_pkg::S_STATUS;
					end
					rre_pkg::REQ_TIDY: begin
						more_d  = 2'd2;
						state_d = rre_pkg::S_TIDY_START;
					end
					rre_pkg::REQ_QUERY: begin
						cmd.q_init = 1'b1;
						state_d    = (stat.cnt == '0) ? rre_pkg::S_STATUS : rre_pkg::S_BB;
					end
					default: state_d = rre_pkg::S_STATUS;
				endcase
			end

			// bounding box scan, with query flags alongside
			rre_pkg::S_BB: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				cmd.bb_init = (i_q == '0);
				cmd.bb_acc  = (i_q != '0);
				cmd.q_acc   = (typ_q == rre_pkg::REQ_QUERY);
				i_d         = i_q + 1'b1;
				if (i_d == stat.cnt)
					state_d = (typ_q == rre_pkg::REQ_QUERY) ? rre_pkg::S_STATUS
					                                        : rre_pkg::S_ADD_DEC;
			end

			rre_pkg::S_ADD_DEC: begin
				i_d       = '0;
				lim_d     = stat.cnt;
				clipdel_d = 1'b0;
				if (stat.bb_in_empty) begin
					state_d = rre_pkg::S_APPEND_OP;
				end else if (stat.bb_in_same) begin
					cmd.cnt_op = rre_pkg::CNT_ZERO;
					state_d    = rre_pkg::S_APPEND_OP;
				end else if (stat.in_op_same) begin
					state_d = rre_pkg::S_MG_FIND;
				end else begin
					state_d = rre_pkg::S_SCAN;
				end
			end

			// operand inside one entry already: nothing to add
			rre_pkg::S_MG_FIND: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				if (i_q >= lim_q)
					state_d = rre_pkg::S_SCAN;
				else if (!stat.rd_ovl)
					i_d = i_q + 1'b1;
				else if (stat.rd_encl)
					state_d = rre_pkg::S_STATUS;
				else
					state_d = rre_pkg::S_SCAN;
			end

			// find next overlapped entry to split
			rre_pkg::S_SCAN: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				if (i_q >= lim_q) begin
					state_d = sub_q ? rre_pkg::S_STATUS : rre_pkg::S_APPEND_OP;
				end else if (!stat.rd_ovl) begin
					i_d = i_q + 1'b1;
				end else begin
					cmd.load_e = 1'b1;
					j_d        = i_q;
					state_d    = rre_pkg::S_DEL;
				end
			end

			// delete entry j by shifting the tail down
			rre_pkg::S_DEL: begin
				cmd.rd_addr = j_inc[rre_pkg::IDX_W-1:0];
				if (j_inc < stat.cnt) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = j_q[rre_pkg::IDX_W-1:0];
					cmd.wr_src  = rre_pkg::W_RD;
					j_d         = j_inc;
				end else begin
					cmd.cnt_op = rre_pkg::CNT_DEC;
					frag_d     = 2'd0;
					state_d    = clipdel_q ? rre_pkg::S_CLIP : rre_pkg::S_FRAG;
				end
			end

			// append the needed fragments, one per cycle
			rre_pkg::S_FRAG: begin
				cmd.frag_sel = frag_q;
				if (stat.frag_need[frag_q] && !stat.err) begin
					if (stat.cnt >= rre_pkg::MAX_CNT) begin
						cmd.cnt_op  = rre_pkg::CNT_ZERO;
						cmd.err_set = 1'b1;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = stat.cnt[rre_pkg::IDX_W-1:0];
						cmd.wr_src  = rre_pkg::W_FRAG;
						cmd.cnt_op  = rre_pkg::CNT_INC;
					end
				end
				frag_d = frag_q + 1'b1;
				if (frag_q == 2'd3)
					state_d = rre_pkg::S_SPL_DONE;
			end

			rre_pkg::S_SPL_DONE: begin
				if (stat.err) begin
					state_d = rre_pkg::S_STATUS;
				end else begin
					lim_d   = lim_q - 1'b1;
					state_d = sub_q ? rre_pkg::S_EMIT_PIECE : rre_pkg::S_SCAN;
				end
			end

			rre_pkg::S_EMIT_PIECE: begin
				cmd.emit = 1'b1;
				cmd.kind = rre_pkg::KIND_PIECE;
				cmd.show = rre_pkg::SHOW_PIECE;
				if (stat.out_free)
					state_d = rre_pkg::S_SCAN;
			end

			rre_pkg::S_APPEND_OP: begin
				if (!stat.err) begin
					if (stat.cnt >= rre_pkg::MAX_CNT) begin
						cmd.cnt_op  = rre_pkg::CNT_ZERO;
						cmd.err_set = 1'b1;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = stat.cnt[rre_pkg::IDX_W-1:0];
						cmd.wr_src  = rre_pkg::W_OP;
						cmd.cnt_op  = rre_pkg::CNT_INC;
					end
				end
				state_d = rre_pkg::S_STATUS;
			end

			// clip each entry, dropping those that become empty
			rre_pkg::S_CLIP: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				if (i_q >= stat.cnt) begin
					state_d = rre_pkg::S_STATUS;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = i_q[rre_pkg::IDX_W-1:0];
					cmd.wr_src  = rre_pkg::W_CLIP;
					if (stat.clip_empty) begin
						j_d       = i_q;
						clipdel_d = 1'b1;
						state_d   = rre_pkg::S_DEL;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end

			rre_pkg::S_OFS: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				if (i_q >= stat.cnt) begin
					state_d = rre_pkg::S_STATUS;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = i_q[rre_pkg::IDX_W-1:0];
					cmd.wr_src  = rre_pkg::W_OFS;
					i_d         = i_q + 1'b1;
				end
			end

			// tidy: alternate row and column passes
			rre_pkg::S_TIDY_START: begin
				if (stat.cnt > 5'd1 && more_q != 2'd0) begin
					more_d  = more_q - 1'b1;
					cols_d  = 1'b0;
					state_d = rre_pkg::S_PASS_INIT;
				end else begin
					state_d = rre_pkg::S_STATUS;
				end
			end

			rre_pkg::S_PASS_INIT: begin
				last_d   = stat.cnt - 1'b1;
				i_d      = stat.cnt - 1'b1;
				merged_d = 1'b0;
				state_d  = rre_pkg::S_TIDY_A;
			end

			rre_pkg::S_TIDY_A: begin
				cmd.rd_addr = i_q[rre_pkg::IDX_W-1:0];
				if (i_q == '0) begin
					state_d = rre_pkg::S_PASS_END;
				end else begin
					cmd.load_a = 1'b1;
					j_d        = i_q - 1'b1;
					state_d    = rre_pkg::S_TIDY_P;
				end
			end

			rre_pkg::S_TIDY_P: begin
				cmd.rd_addr = j_q[rre_pkg::IDX_W-1:0];
				if (stat.tidy_hit) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = j_q[rre_pkg::IDX_W-1:0];
					cmd.wr_src  = rre_pkg::W_TIDY;
					merged_d    = 1'b1;
					if (i_q != last_q) begin
						state_d = rre_pkg::S_TIDY_MV;
					end else begin
						cmd.cnt_op = rre_pkg::CNT_DEC;
						last_d     = last_q - 1'b1;
						i_d        = i_q - 1'b1;
						state_d    = rre_pkg::S_TIDY_A;
					end
				end else if (j_q == '0) begin
					i_d     = i_q - 1'b1;
					state_d = rre_pkg::S_TIDY_A;
				end else begin
					j_d = j_q - 1'b1;
				end
			end

			// fill the merged slot with the last entry
			rre_pkg::S_TIDY_MV: begin
				cmd.rd_addr = last_q[rre_pkg::IDX_W-1:0];
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = i_q[rre_pkg::IDX_W-1:0];
				cmd.wr_src  = rre_pkg::W_RD;
				cmd.cnt_op  = rre_pkg::CNT_DEC;
				last_d      = last_q - 1'b1;
				i_d         = i_q - 1'b1;
				state_d     = rre_pkg::S_TIDY_A;
			end

			rre_pkg::S_PASS_END: begin
				if (!cols_q && more_m != 2'd0) begin
					more_d  = more_m - 1'b1;
					cols_d  = 1'b1;
					state_d = rre_pkg::S_PASS_INIT;
				end else begin
					more_d  = more_m;
					state_d = rre_pkg::S_TIDY_START;
				end
			end

			// final status transfer
			rre_pkg::S_STATUS: begin
				cmd.emit    = 1'b1;
				cmd.last    = 1'b1;
				cmd.rd_addr = idx_q;
				if (typ_q == rre_pkg::REQ_READ) begin
					if ({1'b0, idx_q} < stat.cnt) begin
						cmd.kind = rre_pkg::KIND_ENTRY;
						cmd.show = rre_pkg::SHOW_RD;
					end else begin
						cmd.kind = rre_pkg::KIND_RANGE;
						cmd.show = rre_pkg::SHOW_ZERO;
					end
				end else if (typ_q == rre_pkg::REQ_QUERY) begin
					cmd.kind  = rre_pkg::KIND_STATUS;
					cmd.show  = rre_pkg::SHOW_BB;
					cmd.use_q = 1'b1;
				end else begin
					cmd.kind = rre_pkg::KIND_STATUS;
					cmd.show = rre_pkg::SHOW_ZERO;
				end
				if (stat.out_free)
					state_d = rre_pkg::S_IDLE;
			end

			default: state_d = rre_pkg::S_IDLE;
		endcase
	end

endmodule

// File: src/rectangle_region_engine.sv
// ----------------------------------------------------------------------------
// rectangle_region_engine
// Clipping region kept as a list of up to 16 disjoint rectangles.
// ----------------------------------------------------------------------------
// Requests arrive on req (req_valid/req_stall) and are taken one at a time:
// req_stall stays high from the transfer until the last result of that
// request has been loaded into the output register.
// Results leave on rsp (rsp_valid/rsp_stall); a subtract gives one removed
// piece per split entry, every request ends with one status result (for a
// read, the entry or range result) that carries last. While rsp_stall is
// high the output register holds its result and the controller waits.
// Work per request, with the one-entry-per-cycle store port:
//   clear, read entry, empty add: no scan of the list
//   clip, offset, query: one scan of the list (plus shifts on deletions)
//   add or subtract: a scan of the list, plus per split up to count shifts and 4 appends
//   tidy: row and column passes, each scanning pairs of entries
// Reset empties the list and clears the error flag; store entries are left
// unwritten and only entries below the count are ever used.
// ----------------------------------------------------------------------------
module rectangle_region_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rre_pkg::req_t     req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rre_pkg::rsp_t     rsp
);

	rre_pkg::dp_cmd_t  cmd;
	rre_pkg::dp_stat_t stat;

	rre_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req.req_type),
		.entry_index (req.entry_index),
		.stat        (stat),
		.cmd         (cmd)
	);

	rre_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
